FILE: rtl/core/assert_macros.svh
// Assertion helpers included by host_timeout_table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Check that one condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (res)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, cond, res)
`endif

`endif

FILE: rtl/core/htt_pkg.sv
package htt_pkg;
    localparam int HTT_TABLE_DEPTH = 64;
    localparam int HTT_WIN_BASE    = 60;
    localparam int HTT_HOLD_SECS   = 120;
    localparam int HTT_COUNT_MAX   = 10;
    localparam int HTT_IN_BITS     = 168;
    localparam int HTT_OUT_BITS    = 8;

    typedef struct packed {
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] stamp;
        logic [3:0]  count;
    } entry_t;
endpackage

FILE: rtl/core/htt_cell.sv
module htt_cell
    import htt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t d,
    output entry_t q
);
    entry_t entry_reg;

    // Clear on reset, take the neighbor's entry on a shift, hold otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else if (shift_en) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule

FILE: rtl/core/host_timeout_table.sv
// Host failure table. Entries sit in a ring of TABLE_DEPTH cells that rotates
// one place per cycle, in the scan and apply states only, past a single compare
// unit at cell 0. A query makes one full rotation to find the host, then a
// decide step and the reply; a report may add a second rotation, writing
// the changed entry as it passes the ring input. One item is in work at a
// time; a finished reply waits in the output register while the next item runs.
// A query whose reply finds the output register still held by an earlier reply
// waits in the reply state until m_axis_tready frees the register.
module host_timeout_table
    import htt_pkg::*;
#(
    parameter int TABLE_DEPTH = HTT_TABLE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [4:0]              cfg_wr_data,   // retry_jitter
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // addr_family, addr_high, addr_low, time_now, failed, zero pad
    input  logic [HTT_IN_BITS-1:0]  s_axis_tdata,
    input  logic                    s_axis_tuser,  // mode
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // skip_host, host_known, zero pad
    output logic [HTT_OUT_BITS-1:0] m_axis_tdata
);
    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_REPLY  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [IDXW-1:0] idx_reg;
    logic [4:0] jitter_reg;
    logic seen_reg;

    // Item registers
    logic        mode_reg, fam_reg, failed_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [31:0] now_reg;

    // Scan results
    logic            hit_reg, empty_reg;
    logic [IDXW-1:0] hit_idx_reg, empty_idx_reg, best_idx_reg, target_reg;
    logic [31:0]     hit_time_reg;
    logic [3:0]      hit_count_reg;
    logic [32:0]     best_key_reg;
    entry_t          new_entry_reg;

    logic out_valid_reg;
    logic [1:0] out_data_reg;

    entry_t ring_q [TABLE_DEPTH];
    entry_t head, feed;
    logic shift_en, idx_last, match;
    logic [32:0] key;
    logic [12:0] window;
    logic [31:0] age;
    logic out_free;

    assign head     = ring_q[0];
    assign idx_last = (idx_reg == IDXW'(TABLE_DEPTH - 1));
    assign shift_en = (state_reg == ST_SCAN) || (state_reg == ST_APPLY);
    assign feed     = ((state_reg == ST_APPLY) && (idx_reg == target_reg))
                      ? new_entry_reg : head;

    // Ring of cells, cell 0 holds the entry under inspection
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ring
        htt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d        ((k == TABLE_DEPTH - 1) ? feed : ring_q[(k + 1) % TABLE_DEPTH]),
            .q        (ring_q[k])
        );
    end

    // Compare the head entry against the item
    assign match = (head.family == fam_reg) &&
                   (fam_reg ? (head.addr_high == hi_reg && head.addr_low == lo_reg)
                            : (head.addr_low[31:0] == lo_reg[31:0]));
    assign key    = {1'b0, head.stamp} + {19'd0, head.count, 10'd0};
    assign window = {7'(HTT_WIN_BASE) + {2'd0, jitter_reg}, 6'd0};
    assign age    = now_reg - hit_time_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (idx_last) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!mode_reg) begin
                    state_next = ST_REPLY;
                end else if (!failed_reg) begin
                    state_next = (seen_reg && hit_reg) ? ST_APPLY : ST_IDLE;
                end else if (hit_reg && hit_count_reg != 4'd0 &&
                             {1'b0, now_reg} < {1'b0, hit_time_reg} + 33'(HTT_HOLD_SECS)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:  if (idx_last) state_next = ST_IDLE;
            ST_REPLY:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            jitter_reg    <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) jitter_reg <= cfg_wr_data;
            if (shift_en) idx_reg <= idx_last ? '0 : idx_reg + IDXW'(1);
            if (state_reg == ST_DECIDE && !mode_reg) seen_reg <= hit_reg;
            if (state_reg == ST_REPLY && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item, track the scan, build the replacement entry and the reply
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) begin
            mode_reg   <= s_axis_tuser;
            fam_reg    <= s_axis_tdata[0];
            hi_reg     <= s_axis_tdata[0] ? s_axis_tdata[64:1] : 64'd0;
            lo_reg     <= s_axis_tdata[0] ? s_axis_tdata[128:65]
                                          : {32'd0, s_axis_tdata[96:65]};
            now_reg    <= s_axis_tdata[160:129];
            failed_reg <= s_axis_tdata[161];
            hit_reg    <= 1'b0;
            empty_reg  <= 1'b0;
        end
        if (state_reg == ST_SCAN) begin
            if (!hit_reg && match) begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= idx_reg;
                hit_time_reg  <= head.stamp;
                hit_count_reg <= head.count;
            end
            if (!empty_reg && head.count == 4'd0) begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= idx_reg;
            end
            if (idx_reg == '0 || key < best_key_reg) begin
                best_key_reg <= key;
                best_idx_reg <= idx_reg;
            end
        end
        if (state_reg == ST_DECIDE) begin
            new_entry_reg.family    <= fam_reg;
            new_entry_reg.addr_high <= hi_reg;
            new_entry_reg.addr_low  <= lo_reg;
            if (!failed_reg) begin
                target_reg            <= hit_idx_reg;
                new_entry_reg.stamp   <= hit_time_reg;
                new_entry_reg.count   <= 4'd0;
            end else if (hit_reg) begin
                target_reg            <= hit_idx_reg;
                new_entry_reg.stamp   <= now_reg;
                new_entry_reg.count   <= (hit_count_reg >= 4'(HTT_COUNT_MAX))
                                         ? 4'(HTT_COUNT_MAX) : hit_count_reg + 4'd1;
            end else begin
                target_reg            <= empty_reg ? empty_idx_reg : best_idx_reg;
                new_entry_reg.stamp   <= now_reg;
                new_entry_reg.count   <= 4'd1;
            end
        end
        if (state_reg == ST_REPLY && out_free) begin
            out_data_reg[1] <= hit_reg;
            out_data_reg[0] <= hit_reg && (hit_count_reg >= 4'd2) &&
                               (age < {19'd0, window});
        end
    end

`include "assert_macros.svh"
    `ASSERT_CLK(a_out_from_reply, aclk, aresetn, $rose(m_axis_tvalid) |-> $past(state_reg == ST_REPLY))
    `ASSERT_CLK(a_accept_starts_scan, aclk, aresetn, (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_SCAN && idx_reg == '0))
    `ASSERT_IMPLY(a_scan_only_idle_accept, aclk, aresetn, shift_en, !s_axis_tready)
endmodule
